### rtl/knxfr_pkg.sv
// Shared types and constants for the bus frame receiver.
package knxfr_pkg;

    localparam int unsigned GAP_W        = 20;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned POS_W        = 5;
    localparam logic [GAP_W-1:0] GAP_RESET_US = 20'd1450;
    localparam logic [3:0]  LEN_NIBBLE_MASK   = 4'hF;
    localparam logic [POS_W-1:0] LEN_BASE     = 5'd8;
    localparam int unsigned HEADER_BYTES      = 6;
    localparam logic [7:0]  CHECK_ALL_ONES    = 8'hFF;

    typedef struct packed {
        logic [7:0]        rx_byte;
        logic [TIME_W-1:0] arrival_time_us;
    } in_word_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             checksum_ok;
        logic             last_of_frame;
    } out_word_t;

    // One finished frame waiting for emission.
    typedef struct packed {
        logic             bank;
        logic [POS_W-1:0] len;
        logic             ok;
    } frame_desc_t;

    // Back end hands a bank back to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

### rtl/knxfr_front.sv
// Front end: gap detection, byte assembly, length and check byte evaluation.
module knxfr_front
    import knxfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 23,
    parameter int unsigned ADDR_W    = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [GAP_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 st_wr_en,
    output logic [ADDR_W-1:0]    st_wr_addr,
    output logic [7:0]           st_wr_data,
    output logic                 desc_push,
    output frame_desc_t          desc_data,
    input  bank_release_t        release_in
);

    localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);
    localparam int unsigned IDX_W = $clog2(FRAME_MAX);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [GAP_W-1:0]  gap_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        xor_reg, xor_next;
    logic [3:0]        nib_reg, nib_next;
    logic              wr_bank_reg;
    logic [1:0]        busy_reg, busy_next;

    logic              accept;
    logic [TIME_W-1:0] elapsed;
    logic              gap_hit;
    logic [CNT_W-1:0]  cnt_base, cnt_inc;
    logic [7:0]        xor_base;
    logic              store;
    logic [POS_W-1:0]  frame_len;
    logic              complete;
    logic [IDX_W-1:0]  wr_idx;

    assign s_ready = !busy_reg[wr_bank_reg];
    assign accept  = s_valid && s_ready;

    always_comb begin
        elapsed   = s_data.arrival_time_us - prev_time_reg;
        gap_hit   = elapsed > {{(TIME_W-GAP_W){1'b0}}, gap_reg};
        cnt_base  = gap_hit ? '0 : cnt_reg;
        xor_base  = gap_hit ? 8'h00 : xor_reg;
        store     = cnt_base < CNT_W'(FRAME_MAX);
        cnt_inc   = cnt_base + CNT_W'(1);
        frame_len = LEN_BASE + {1'b0, nib_reg & LEN_NIBBLE_MASK};
        // length nibble is valid once byte 5 is in, and len >= 8 ensures that
        complete  = store && (CMP_W'(cnt_inc) == CMP_W'(frame_len));
        wr_idx    = cnt_base[IDX_W-1:0];

        cnt_next = cnt_reg;
        xor_next = xor_reg;
        nib_next = nib_reg;
        if (accept) begin
            cnt_next = store ? cnt_inc : cnt_base;
            xor_next = store ? (xor_base ^ s_data.rx_byte) : xor_base;
            if (store && cnt_base == CNT_W'(HEADER_BYTES - 1)) begin
                nib_next = s_data.rx_byte[3:0];
            end
        end

        busy_next = busy_reg;
        if (release_in.valid) begin
            busy_next[release_in.bank] = 1'b0;
        end
        if (accept && complete) begin
            busy_next[wr_bank_reg] = 1'b1;
        end
    end

    assign st_wr_en   = accept && store;
    assign st_wr_addr = wr_bank_reg ? ADDR_W'(FRAME_MAX) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
    assign st_wr_data = s_data.rx_byte;

    assign desc_push      = accept && complete;
    assign desc_data.bank = wr_bank_reg;
    assign desc_data.len  = frame_len;
    // check byte must equal ~XOR of earlier bytes
    assign desc_data.ok   = (xor_base ^ s_data.rx_byte) == CHECK_ALL_ONES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg       <= GAP_RESET_US;
            prev_time_reg <= '0;
            cnt_reg       <= '0;
            xor_reg       <= '0;
            nib_reg       <= '0;
            wr_bank_reg   <= 1'b0;
            busy_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                gap_reg <= cfg_wr_data;
            end
            if (accept) begin
                prev_time_reg <= s_data.arrival_time_us;
            end
            if (accept && complete) begin
                wr_bank_reg <= !wr_bank_reg;
            end
            cnt_reg  <= cnt_next;
            xor_reg  <= xor_next;
            nib_reg  <= nib_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### rtl/knxfr_desc_fifo.sv
// Two-entry queue of finished frame descriptors between front and back end.
module knxfr_desc_fifo
    import knxfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_data,
    input  logic        pop,
    output logic        pop_valid,
    output frame_desc_t pop_data
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop && pop_valid})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && pop_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/knxfr_back.sv
// Back end: two-bank frame store and the sequencer that emits a frame word by word.
module knxfr_back
    import knxfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 23,
    parameter int unsigned ADDR_W    = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              st_wr_en,
    input  logic [ADDR_W-1:0] st_wr_addr,
    input  logic [7:0]        st_wr_data,
    input  logic              desc_valid,
    input  frame_desc_t       desc_data,
    output logic              desc_pop,
    output bank_release_t     release_out,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);

    localparam int unsigned IDX_W = $clog2(FRAME_MAX);

    logic [7:0]       store_mem [2*FRAME_MAX];
    logic [7:0]       rd_data_reg;

    back_state_t      state_reg, state_next;
    logic             bank_reg;
    logic [POS_W-1:0] len_reg;
    logic             ok_reg;
    logic [POS_W-1:0] pos_reg;

    logic             rd_v_reg;
    logic [POS_W-1:0] rd_pos_reg;
    logic             rd_last_reg;
    logic             rd_ok_reg;

    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             out_free;
    logic             issue;
    logic             is_last;
    logic [IDX_W-1:0] rd_idx;
    logic [ADDR_W-1:0] rd_addr;

    assign out_free = !m_valid_reg || m_ready;
    assign is_last  = pos_reg == len_reg - POS_W'(1);
    assign rd_idx   = IDX_W'(pos_reg);
    assign rd_addr  = bank_reg ? ADDR_W'(FRAME_MAX) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

    always_comb begin
        state_next = state_reg;
        desc_pop   = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (desc_valid) begin
                    desc_pop   = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                issue = !rd_v_reg || out_free;
                if (issue && is_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // bank is free once its last byte has been read out
    assign release_out.valid = issue && is_last;
    assign release_out.bank  = bank_reg;

    always_ff @(posedge aclk) begin
        if (st_wr_en) begin
            store_mem[st_wr_addr] <= st_wr_data;
        end
        if (issue) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (desc_pop) begin
            bank_reg <= desc_data.bank;
            len_reg  <= desc_data.len;
            ok_reg   <= desc_data.ok;
        end
        if (issue) begin
            rd_pos_reg  <= pos_reg;
            rd_last_reg <= is_last;
            rd_ok_reg   <= ok_reg;
        end
        if (out_free) begin
            m_data_reg.frame_byte    <= rd_data_reg;
            m_data_reg.byte_position <= rd_pos_reg;
            m_data_reg.checksum_ok   <= rd_ok_reg;
            m_data_reg.last_of_frame <= rd_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            pos_reg     <= '0;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (desc_pop) begin
                pos_reg <= '0;
            end else if (issue) begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            if (issue) begin
                rd_v_reg <= 1'b1;
            end else if (out_free) begin
                rd_v_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= rd_v_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/knx_frame_receiver_unit.sv
// Top level of the bus frame receiver: front end, descriptor queue, back end.
//
//  channel | ports                        | word
//  --------+------------------------------+---------------------------------------
//  in      | s_valid / s_ready / s_data   | rx_byte, arrival_time_us
//  out     | m_valid / m_ready / m_data   | frame_byte, byte_position, checksum_ok,
//          |                              | last_of_frame
//  config  | cfg_wr_en / cfg_wr_data      | gap_limit_us, no wait
//
// An input word is taken while s_valid and s_ready are high. A finished frame of L bytes
// leaves at one word per cycle while m_ready is high, via descriptor pop, store read and output.
// Two store banks: s_ready drops only while the bank to be filled still holds a
// frame that has not been read out. Reset is synchronous; the store needs no clearing.
// Stalls on m_ready hold the read pipeline and do not block input until both banks fill.
module knx_frame_receiver_unit
    import knxfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 23
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [GAP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    localparam int unsigned ADDR_W = $clog2(2 * FRAME_MAX);

    logic              st_wr_en;
    logic [ADDR_W-1:0] st_wr_addr;
    logic [7:0]        st_wr_data;
    logic              desc_push;
    frame_desc_t       desc_in;
    logic              desc_pop;
    logic              desc_valid;
    frame_desc_t       desc_out;
    bank_release_t     bank_release;

    knxfr_front #(
        .FRAME_MAX (FRAME_MAX),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .desc_push   (desc_push),
        .desc_data   (desc_in),
        .release_in  (bank_release)
    );

    knxfr_desc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (desc_push),
        .push_data (desc_in),
        .pop       (desc_pop),
        .pop_valid (desc_valid),
        .pop_data  (desc_out)
    );

    knxfr_back #(
        .FRAME_MAX (FRAME_MAX),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .desc_valid  (desc_valid),
        .desc_data   (desc_out),
        .desc_pop    (desc_pop),
        .release_out (bank_release),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### rtl/knxfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module knxfr_checker
    import knxfr_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 23
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // a frame is at least 8 bytes, so its last word sits at position 7 or beyond
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_of_frame |-> m_data.byte_position >= POS_W'(7))
        else $error("frame ended too early");

    // positions never run past the buffer
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.byte_position) < FRAME_MAX)
        else $error("byte position beyond buffer");

    // after a non-final word is taken, the next word shown continues the frame
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_frame ##1 m_valid
        |-> m_data.byte_position == $past(m_data.byte_position) + POS_W'(1))
        else $error("byte position skipped");

endmodule

bind knx_frame_receiver_unit knxfr_checker #(.FRAME_MAX(FRAME_MAX)) u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
